@@ design/bmv_pkg.sv @@
// Shared request/result types and fixed field widths for the block mean/variance unit.
package bmv_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int SQ_TERM_W   = 2 * SAMPLE_W - 1;
  localparam int MEAN_W      = 16;
  localparam int VAR_W       = 32;
  localparam int COUNT_OUT_W = 11;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } sample_req_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [COUNT_OUT_W-1:0]   count;
    logic                     overflow;
  } stats_res_t;

endpackage

@@ design/bmv_front.sv @@
// Front end: accepts samples, keeps count, sum and sum of squares, hands off closed blocks.
module bmv_front
  import bmv_pkg::*;
#(
  parameter int MAX_BLOCK = 1024,
  localparam int CW      = $clog2(MAX_BLOCK + 1),
  localparam int SUMW    = SAMPLE_W + CW,
  localparam int SQW     = SQ_TERM_W - 1 + CW,
  localparam int ENTRY_W = 1 + CW + SUMW + SQW
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sample_req_t         req,
  output logic                push_valid,
  input  logic                push_ready,
  output logic [ENTRY_W-1:0]  push_data
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_BLOCK);

  logic                   accept;
  logic [CW-1:0]          count, count_next;
  logic signed [SUMW-1:0] sum, sum_next;
  logic [SQW-1:0]         sq_sum, sq_sum_next;
  logic                   exceeded, exceeded_next;
  logic signed [2*SAMPLE_W-1:0] square;

  assign req_ready = push_ready;
  assign accept    = req_valid & req_ready;
  assign square    = req.sample * req.sample;

  always_comb begin
    count_next    = count;
    sum_next      = sum;
    sq_sum_next   = sq_sum;
    exceeded_next = exceeded;
    if (count < MAX_CNT) begin
      count_next  = count + CW'(1);
      sum_next    = sum + SUMW'(req.sample);
      sq_sum_next = sq_sum + SQW'(square[SQ_TERM_W-1:0]);
    end else begin
      exceeded_next = 1'b1;
    end
  end

  assign push_valid = accept & req.last;
  assign push_data  = {exceeded_next, count_next, sum_next, sq_sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sum      <= '0;
      sq_sum   <= '0;
      exceeded <= 1'b0;
    end else if (accept) begin
      if (req.last) begin
        count    <= '0;
        sum      <= '0;
        sq_sum   <= '0;
        exceeded <= 1'b0;
      end else begin
        count    <= count_next;
        sum      <= sum_next;
        sq_sum   <= sq_sum_next;
        exceeded <= exceeded_next;
      end
    end
  end

endmodule

@@ design/bmv_queue.sv @@
// Two-entry queue of closed block totals between front end and back end.
module bmv_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  logic [DATA_W-1:0] slots [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        fill;
  logic              do_push, do_pop;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop_valid & pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

@@ design/bmv_back.sv @@
// Back end: shift-add products and restoring division for mean and unbiased variance.
module bmv_back
  import bmv_pkg::*;
#(
  parameter int MAX_BLOCK = 1024,
  localparam int CW      = $clog2(MAX_BLOCK + 1),
  localparam int SUMW    = SAMPLE_W + CW,
  localparam int SQW     = SQ_TERM_W - 1 + CW,
  localparam int ENTRY_W = 1 + CW + SUMW + SQW
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [ENTRY_W-1:0] pop_data,
  output logic               res_valid,
  input  logic               res_ready,
  output stats_res_t         res
);

  localparam int MAGW    = SUMW - 1;
  localparam int NUMW    = SQW + CW;
  localparam int DENW    = 2 * CW;
  localparam int CNTW    = $clog2((MAGW > VAR_W) ? MAGW : VAR_W);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_SUB   = 3'd2;
  localparam logic [2:0] ST_DIVLD = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]      state;
  logic [CNTW-1:0] cnt;

  // unpacked queue entry
  logic            q_exc;
  logic [CW-1:0]   q_n;
  logic [SUMW-1:0] q_sum;
  logic [SQW-1:0]  q_sq;
  logic [SUMW-1:0] q_abs;

  // block registers
  logic            exc, neg, var_zero, sat;
  logic [CW-1:0]   n;
  logic [MAGW-1:0] mag;

  // shift-add multipliers
  logic [CW-1:0]   mplr_n;
  logic [MAGW-1:0] mplr_mag;
  logic [NUMW-1:0] mcand_s2, mcand_mag, acc_ns2, acc_sq;
  logic [DENW-1:0] mcand_nm1, den;

  // dividers
  logic [NUMW-1:0]   diff;
  logic [NUMW:0]     diff_ext;
  logic [DENW-1:0]   vrem;
  logic [VAR_W-1:0]  vlow, vq;
  logic [DENW:0]     vtrial;
  logic              vfit;
  logic [CW-1:0]     mrem;
  logic [MEAN_W-1:0] mlow, mq;
  logic [CW:0]       mtrial;
  logic              mfit;

  logic              res_load;
  logic [MEAN_W-1:0] mean_bits;

  assign {q_exc, q_n, q_sum, q_sq} = pop_data;
  assign q_abs     = q_sum[SUMW-1] ? (~q_sum + SUMW'(1)) : q_sum;
  assign pop_ready = (state == ST_IDLE);

  assign diff_ext = {1'b0, acc_ns2} - {1'b0, acc_sq};
  assign vtrial   = {vrem, vlow[VAR_W-1]};
  assign vfit     = (vtrial >= {1'b0, den});
  assign mtrial   = {mrem, mlow[MEAN_W-1]};
  assign mfit     = (mtrial >= {1'b0, n});

  assign res_load  = (state == ST_DONE) && (!res_valid || res_ready);
  assign mean_bits = neg ? (~mq + MEAN_W'(1)) : mq;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_MUL;
            cnt   <= '0;
          end
        end
        ST_MUL: begin
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(MAGW - 1)) state <= ST_SUB;
        end
        ST_SUB:   state <= ST_DIVLD;
        ST_DIVLD: begin
          state <= ST_DIV;
          cnt   <= '0;
        end
        ST_DIV: begin
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(VAR_W - 1)) state <= ST_DONE;
        end
        ST_DONE: begin
          if (res_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        exc       <= q_exc;
        n         <= q_n;
        neg       <= q_sum[SUMW-1];
        mag       <= q_abs[MAGW-1:0];
        mplr_n    <= q_n;
        mplr_mag  <= q_abs[MAGW-1:0];
        mcand_s2  <= NUMW'(q_sq);
        mcand_mag <= NUMW'(q_abs[MAGW-1:0]);
        mcand_nm1 <= DENW'(q_n - CW'(1));
        acc_ns2   <= '0;
        acc_sq    <= '0;
        den       <= '0;
      end
      ST_MUL: begin
        if (mplr_n[0]) begin
          acc_ns2 <= acc_ns2 + mcand_s2;
          den     <= den + mcand_nm1;
        end
        if (mplr_mag[0]) acc_sq <= acc_sq + mcand_mag;
        mplr_n    <= mplr_n >> 1;
        mplr_mag  <= mplr_mag >> 1;
        mcand_s2  <= mcand_s2 << 1;
        mcand_nm1 <= mcand_nm1 << 1;
        mcand_mag <= mcand_mag << 1;
      end
      ST_SUB: begin
        diff     <= diff_ext[NUMW-1:0];
        var_zero <= (n < CW'(2)) | diff_ext[NUMW];
      end
      ST_DIVLD: begin
        // upper numerator bits seed the remainder; quotient beyond 32 bits saturates
        vrem <= DENW'(diff[NUMW-1:VAR_W]);
        vlow <= diff[VAR_W-1:0];
        sat  <= (DENW'(diff[NUMW-1:VAR_W]) >= den);
        vq   <= '0;
        mrem <= CW'(mag[MAGW-1:MEAN_W]);
        mlow <= mag[MEAN_W-1:0];
        mq   <= '0;
      end
      ST_DIV: begin
        vrem <= vfit ? DENW'(vtrial - {1'b0, den}) : vtrial[DENW-1:0];
        vlow <= vlow << 1;
        vq   <= {vq[VAR_W-2:0], vfit};
        if (cnt < CNTW'(MEAN_W)) begin
          mrem <= mfit ? CW'(mtrial - {1'b0, n}) : mtrial[CW-1:0];
          mlow <= mlow << 1;
          mq   <= {mq[MEAN_W-2:0], mfit};
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res.mean     <= exc ? '0 : mean_bits;
      res.variance <= (exc || var_zero) ? '0 : (sat ? '1 : vq);
      res.count    <= COUNT_OUT_W'(n);
      res.overflow <= exc;
    end
  end

endmodule

@@ design/block_mean_variance_top.sv @@
// Top level: block mean and unbiased variance, front end, block queue and back end.
// Samples are accepted one per cycle while the queue has room.
// Each closed block takes the back end through one serial shift-add pass over the
// MAGW-bit magnitude, MAGW = 15+clog2(MAX_BLOCK+1), then a subtract, a divider load,
// a 32-step divider and the result register; two closed blocks can wait in the queue.
// Synchronous active-high rst clears accumulators, queue, sequencer and result valid.
module block_mean_variance_top
  import bmv_pkg::*;
#(
  parameter int MAX_BLOCK = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  sample_req_t req,
  output logic        res_valid,
  input  logic        res_ready,
  output stats_res_t  res
);

  // entry = {overflow, count, sum, sum of squares}
  localparam int CW      = $clog2(MAX_BLOCK + 1);
  localparam int ENTRY_W = 1 + CW + (SAMPLE_W + CW) + (SQ_TERM_W - 1 + CW);

  logic               push_valid, push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic               pop_valid, pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  // Front end: one request per cycle while the queue has room.
  bmv_front #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decouples sample intake from the long per-block arithmetic.
  bmv_queue #(
    .DATA_W(ENTRY_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: serial products, then mean and variance dividers side by side;
  // the result register lets the next block start while a result waits.
  bmv_back #(
    .MAX_BLOCK(MAX_BLOCK)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
